// ----- hdl/air_quality_index_composite_assert.svh -----
// Assertion macros for the air quality index composite block
`ifndef AIR_QUALITY_INDEX_COMPOSITE_ASSERT_SVH
`define AIR_QUALITY_INDEX_COMPOSITE_ASSERT_SVH

// same-cycle implication
`define AQI_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("aqi assertion failed");

// next-cycle implication
`define AQI_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("aqi assertion failed");

`endif

// ----- hdl/aqi_pkg.sv -----
// Shared types, breakpoint tables and slope constants for the AQI block
package aqi_pkg;

  localparam int unsigned NSeg      = 7;
  localparam int unsigned SegW      = 3;
  localparam int unsigned ConcW     = 14;
  localparam int unsigned DxW       = 11;
  localparam int unsigned SlopeFrac = 24;
  localparam int unsigned SlopeW    = 25;
  localparam int unsigned AqiW      = 9;
  localparam int unsigned ProdW     = DxW + SlopeW;
  localparam logic [AqiW-1:0] AqiTop = 9'd500;

  typedef enum logic [1:0] {
    SRC_PM25 = 2'd0,
    SRC_PM10 = 2'd1,
    SRC_CO   = 2'd2
  } src_e;

  typedef struct packed {
    logic [ConcW-1:0]  clo;
    logic [ConcW-1:0]  chi;
    logic [AqiW-1:0]   ilo;
    logic [SlopeW-1:0] slope;
  } seg_t;

  typedef struct packed {
    logic en_a;
    logic en_b;
  } lane_en_t;

  typedef struct packed {
    logic [AqiW-1:0] sub;
    logic            over;
  } lane_res_t;

  localparam seg_t Pm25Tab [NSeg] = '{
    '{14'd0,    14'd120,  9'd0,   25'(((64'd50 << SlopeFrac) + 64'd119)  / 64'd120)},
    '{14'd121,  14'd354,  9'd51,  25'(((64'd49 << SlopeFrac) + 64'd232)  / 64'd233)},
    '{14'd355,  14'd554,  9'd101, 25'(((64'd49 << SlopeFrac) + 64'd198)  / 64'd199)},
    '{14'd555,  14'd1504, 9'd151, 25'(((64'd49 << SlopeFrac) + 64'd948)  / 64'd949)},
    '{14'd1505, 14'd2504, 9'd201, 25'(((64'd99 << SlopeFrac) + 64'd998)  / 64'd999)},
    '{14'd2505, 14'd3504, 9'd301, 25'(((64'd99 << SlopeFrac) + 64'd998)  / 64'd999)},
    '{14'd3505, 14'd5000, 9'd401, 25'(((64'd99 << SlopeFrac) + 64'd1494) / 64'd1495)}
  };

  localparam seg_t Pm10Tab [NSeg] = '{
    '{14'd0,   14'd54,  9'd0,   25'(((64'd50 << SlopeFrac) + 64'd53) / 64'd54)},
    '{14'd55,  14'd154, 9'd51,  25'(((64'd49 << SlopeFrac) + 64'd98) / 64'd99)},
    '{14'd155, 14'd254, 9'd101, 25'(((64'd49 << SlopeFrac) + 64'd98) / 64'd99)},
    '{14'd255, 14'd354, 9'd151, 25'(((64'd49 << SlopeFrac) + 64'd98) / 64'd99)},
    '{14'd355, 14'd424, 9'd201, 25'(((64'd99 << SlopeFrac) + 64'd68) / 64'd69)},
    '{14'd425, 14'd504, 9'd301, 25'(((64'd99 << SlopeFrac) + 64'd78) / 64'd79)},
    '{14'd505, 14'd604, 9'd401, 25'(((64'd99 << SlopeFrac) + 64'd98) / 64'd99)}
  };

  localparam seg_t CoTab [NSeg] = '{
    '{14'd0,   14'd44,  9'd0,   25'(((64'd50 << SlopeFrac) + 64'd43)  / 64'd44)},
    '{14'd45,  14'd94,  9'd51,  25'(((64'd49 << SlopeFrac) + 64'd48)  / 64'd49)},
    '{14'd95,  14'd124, 9'd101, 25'(((64'd49 << SlopeFrac) + 64'd28)  / 64'd29)},
    '{14'd125, 14'd154, 9'd151, 25'(((64'd49 << SlopeFrac) + 64'd28)  / 64'd29)},
    '{14'd155, 14'd304, 9'd201, 25'(((64'd99 << SlopeFrac) + 64'd148) / 64'd149)},
    '{14'd305, 14'd404, 9'd301, 25'(((64'd99 << SlopeFrac) + 64'd98)  / 64'd99)},
    '{14'd405, 14'd504, 9'd401, 25'(((64'd99 << SlopeFrac) + 64'd98)  / 64'd99)}
  };

  function automatic seg_t seg_entry(src_e src, logic [SegW-1:0] k);
    seg_t s;
    s = Pm25Tab[k];
    unique case (src)
      SRC_PM25: s = Pm25Tab[k];
      SRC_PM10: s = Pm10Tab[k];
      SRC_CO:   s = CoTab[k];
      default:  s = Pm25Tab[k];
    endcase
    return s;
  endfunction

endpackage

// ----- hdl/aqi_lane.sv -----
// One sub-index lane: segment search, then fixed-point interpolation
module aqi_lane #(
  parameter aqi_pkg::src_e Src = aqi_pkg::SRC_PM25
) (
  input  logic                     clk_i,
  input  logic [aqi_pkg::ConcW-1:0] conc_i,
  input  aqi_pkg::lane_en_t        en_i,
  output aqi_pkg::lane_res_t       res_o
);
  import aqi_pkg::*;

  seg_t              seg_tab [NSeg];
  logic [SegW-1:0]   sel;
  logic              over_a;
  logic [ConcW-1:0]  diff;

  logic [DxW-1:0]    dx_q,    dx_d;
  logic [SlopeW-1:0] slope_q, slope_d;
  logic [AqiW-1:0]   ilo_q,   ilo_d;
  logic              over_q;

  logic [ProdW-1:0]  prod;
  logic [ProdW-SlopeFrac:0] sum;
  lane_res_t         res_q, res_d;

  always_comb begin
    for (int k = 0; k < NSeg; k++) begin
      seg_tab[k] = seg_entry(Src, SegW'(k));
    end
    sel = SegW'(NSeg - 1);
    for (int k = NSeg - 1; k >= 0; k--) begin
      if (conc_i <= seg_tab[k].chi) begin
        sel = SegW'(k);
      end
    end
    over_a = conc_i > seg_tab[NSeg-1].chi;
    diff   = conc_i - seg_tab[sel].clo;
    if (over_a) begin
      dx_d    = '0;
      slope_d = '0;
      ilo_d   = AqiTop;
    end else begin
      dx_d    = diff[DxW-1:0];
      slope_d = seg_tab[sel].slope;
      ilo_d   = seg_tab[sel].ilo;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i.en_a) begin
      dx_q    <= dx_d;
      slope_q <= slope_d;
      ilo_q   <= ilo_d;
      over_q  <= over_a;
    end
  end

  always_comb begin
    prod = ProdW'(dx_q) * ProdW'(slope_q);
    sum  = (ProdW-SlopeFrac+1)'(prod[ProdW-1:SlopeFrac]) + (ProdW-SlopeFrac+1)'(ilo_q);
    res_d.over = over_q;
    if (sum > (ProdW-SlopeFrac+1)'(AqiTop)) begin
      res_d.sub = AqiTop;
    end else begin
      res_d.sub = sum[AqiW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i.en_b) begin
      res_q <= res_d;
    end
  end

  assign res_o = res_q;

endmodule

// ----- hdl/aqi_merge.sv -----
// Merge stage: maximum of the lanes, dominant source and over-range flag
module aqi_merge (
  input  logic                        clk_i,
  input  logic                        en_i,
  input  aqi_pkg::lane_res_t          pm25_i,
  input  aqi_pkg::lane_res_t          pm10_i,
  input  aqi_pkg::lane_res_t          co_i,
  output logic [aqi_pkg::AqiW-1:0]    aqi_composite_o,
  output logic [aqi_pkg::AqiW-1:0]    aqi_pm25_o,
  output logic [aqi_pkg::AqiW-1:0]    aqi_pm10_o,
  output logic [aqi_pkg::AqiW-1:0]    aqi_co_o,
  output aqi_pkg::src_e               dominant_source_o,
  output logic                        over_range_o
);
  import aqi_pkg::*;

  logic [AqiW-1:0] mx_d,  mx_q;
  src_e            dom_d, dom_q;
  logic [AqiW-1:0] a25_q, a10_q, aco_q;
  logic            over_q;

  // ties go to the later source
  always_comb begin
    mx_d  = pm25_i.sub;
    dom_d = SRC_PM25;
    if (pm10_i.sub >= mx_d) begin
      mx_d  = pm10_i.sub;
      dom_d = SRC_PM10;
    end
    if (co_i.sub >= mx_d) begin
      mx_d  = co_i.sub;
      dom_d = SRC_CO;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mx_q   <= mx_d;
      dom_q  <= dom_d;
      a25_q  <= pm25_i.sub;
      a10_q  <= pm10_i.sub;
      aco_q  <= co_i.sub;
      over_q <= pm25_i.over | pm10_i.over | co_i.over;
    end
  end

  assign aqi_composite_o   = mx_q;
  assign aqi_pm25_o        = a25_q;
  assign aqi_pm10_o        = a10_q;
  assign aqi_co_o          = aco_q;
  assign dominant_source_o = dom_q;
  assign over_range_o      = over_q;

endmodule

// ----- hdl/air_quality_index_composite.sv -----
// Top level: three AQI lanes, merge stage and pipeline handshake
// Pipeline stages from input beat to output valid: search, multiply, merge.
// Throughput: one beat per cycle; each stage advances whenever the one after it
// is empty or draining, so a stalled output only blocks once the pipe is full.
// Reset (rst_ni, async, active low) clears the stage valid bits only;
// the lane and merge data registers are not reset.
module air_quality_index_composite (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [13:0]                 pm25_tenths_i,
  input  logic [10:0]                 pm10_ug_i,
  input  logic [9:0]                  co_tenths_ppm_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [8:0]                  aqi_composite_o,
  output logic [8:0]                  aqi_pm25_o,
  output logic [8:0]                  aqi_pm10_o,
  output logic [8:0]                  aqi_co_o,
  output logic [1:0]                  dominant_source_o,
  output logic                        over_range_o
);
  import aqi_pkg::*;

  `include "air_quality_index_composite_assert.svh"

  logic      v1_q, v2_q, v3_q;
  logic      en1, en2, en3;
  lane_en_t  lane_en;
  lane_res_t res_pm25, res_pm10, res_co;
  src_e      dom;

  assign en3        = !v3_q || out_ready_i;
  assign en2        = !v2_q || en3;
  assign en1        = !v1_q || en2;
  assign in_ready_o = en1;
  assign lane_en    = '{en_a: en1, en_b: en2};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (en1) v1_q <= in_valid_i;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
    end
  end

  aqi_lane #(.Src(SRC_PM25)) u_lane_pm25 (
    .clk_i  (clk_i),
    .conc_i (pm25_tenths_i),
    .en_i   (lane_en),
    .res_o  (res_pm25)
  );

  aqi_lane #(.Src(SRC_PM10)) u_lane_pm10 (
    .clk_i  (clk_i),
    .conc_i (ConcW'(pm10_ug_i)),
    .en_i   (lane_en),
    .res_o  (res_pm10)
  );

  aqi_lane #(.Src(SRC_CO)) u_lane_co (
    .clk_i  (clk_i),
    .conc_i (ConcW'(co_tenths_ppm_i)),
    .en_i   (lane_en),
    .res_o  (res_co)
  );

  aqi_merge u_merge (
    .clk_i             (clk_i),
    .en_i              (en3),
    .pm25_i            (res_pm25),
    .pm10_i            (res_pm10),
    .co_i              (res_co),
    .aqi_composite_o   (aqi_composite_o),
    .aqi_pm25_o        (aqi_pm25_o),
    .aqi_pm10_o        (aqi_pm10_o),
    .aqi_co_o          (aqi_co_o),
    .dominant_source_o (dom),
    .over_range_o      (over_range_o)
  );

  assign dominant_source_o = dom;
  assign out_valid_o       = v3_q;

  `AQI_ASSERT_NOW(a_comp_is_max, clk_i, rst_ni, out_valid_o, (aqi_composite_o >= aqi_pm25_o) && (aqi_composite_o >= aqi_pm10_o) && (aqi_composite_o >= aqi_co_o))
  `AQI_ASSERT_NOW(a_dom_tie_rule, clk_i, rst_ni, out_valid_o, (dom == SRC_CO && aqi_composite_o == aqi_co_o) || (dom == SRC_PM10 && aqi_composite_o == aqi_pm10_o && aqi_pm10_o != aqi_co_o) || (dom == SRC_PM25 && aqi_composite_o == aqi_pm25_o && aqi_pm25_o != aqi_pm10_o && aqi_pm25_o != aqi_co_o))
  `AQI_ASSERT_NOW(a_over_saturates, clk_i, rst_ni, out_valid_o && over_range_o, aqi_composite_o == AqiTop)
  `AQI_ASSERT_NEXT(a_stage_holds, clk_i, rst_ni, v1_q && !en2, v1_q && v2_q && v3_q)

endmodule
